// ===== design/rti_pkg.sv =====
`timescale 1ns / 1ps
package rti_pkg;

  localparam int CW        = 20;
  localparam int DIV_BITS  = 20;
  localparam int DIV_FIRST = 7;
  localparam int STG_TM    = DIV_FIRST + DIV_BITS;
  localparam int NSTG      = STG_TM + 10;

  typedef enum logic [2:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_VERTEX_C = 3'd2,
    REG_NORMAL   = 3'd3,
    REG_TAG      = 3'd4
  } reg_idx_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   diff_t;

  typedef struct packed {
    coord_t [2:0]   o;
    coord_t [2:0]   d;
    logic [CW-1:0]  best;
    logic           cond;
  } ray_side_t;

  typedef struct packed {
    logic [59:0]         rem;
    logic [38:0]         den;
    logic [DIV_BITS-1:0] q;
    ray_side_t           side;
  } div_word_t;

  typedef struct packed {
    logic       found;
    logic [1:0] ax1;
    logic [1:0] ax2;
  } axes_t;

  typedef struct packed {
    logic           cond;
    logic           found;
    logic [CW-1:0]  t;
    coord_t [2:0]   p;
    logic [CW-1:0]  best;
  } tail_t;

  // first axis with b-a nonzero, paired with first other axis with c-a nonzero
  function automatic axes_t pick_axes(input logic [2:0] ba_nz, input logic [2:0] ca_nz);
    axes_t r;
    r = '0;
    for (int i = 2; i >= 0; i--) begin
      for (int j = 2; j >= 0; j--) begin
        if (ba_nz[i] && ca_nz[j] && (i != j)) begin
          r.found = 1'b1;
          r.ax1   = 2'(i);
          r.ax2   = 2'(j);
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== design/rti_ray_if.sv =====
`timescale 1ns / 1ps
interface rti_ray_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] origin_x;
  logic signed [19:0] origin_y;
  logic signed [19:0] origin_z;
  logic signed [19:0] dir_x;
  logic signed [19:0] dir_y;
  logic signed [19:0] dir_z;
  logic [19:0]        best_distance;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  best_distance, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                best_distance, output ready);
endinterface

// ===== design/rti_hit_if.sv =====
`timescale 1ns / 1ps
interface rti_hit_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [19:0]        hit_distance;
  logic signed [19:0] point_x;
  logic signed [19:0] point_y;
  logic signed [19:0] point_z;
  logic [19:0]        new_best;
  logic [15:0]        hit_tag;

  modport source (output valid, hit, hit_distance, point_x, point_y, point_z, new_best,
                  hit_tag, input ready);
  modport sink (input valid, hit, hit_distance, point_x, point_y, point_z, new_best,
                hit_tag, output ready);
endinterface

// ===== design/rti_div.sv =====
`timescale 1ns / 1ps
module rti_div import rti_pkg::*; (
  input  logic                clk,
  input  logic [DIV_BITS-1:0] en,
  input  div_word_t           din,
  output div_word_t           dout
);

  div_word_t st [DIV_BITS];

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    div_word_t   prev;
    div_word_t   nx;
    logic [59:0] sh;

    if (k == 0) begin : g_first
      assign prev = din;
    end else begin : g_rest
      assign prev = st[k-1];
    end

    assign sh = 60'(prev.den) << (DIV_BITS - 1 - k);

    always_comb begin
      nx = prev;
      if (prev.rem >= sh) begin
        nx.rem = prev.rem - sh;
        nx.q[DIV_BITS-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= nx;
      end
    end
  end

  assign dout = st[DIV_BITS-1];

endmodule

// ===== design/ray_triangle_intersect_core.sv =====
`timescale 1ns / 1ps
// ray / triangle intersection against one configured triangle, fixed point.
// channels: ray (sink) carries origin, direction and best distance so far;
// result (source) carries hit flag, distance, hit point, new best and tag.
// both are valid/ready; a word moves on a clock edge with valid and ready high.
// configuration: cfg_we, cfg_index, cfg_data write vertex a, b, c, the unit
// normal and the tag; write only while no ray is in flight.
// throughput: one ray per cycle while the receiver does not stall; the depth
// is set by the 20-stage restoring divider for the distance
// and the multiply stages of the plane and barycentric solves.
// every stage has its own valid bit and moves when the stage after it is free,
// so when the receiver stalls the pipe fills up bubble by bubble and ray.ready
// drops only once every stage holds a word; nothing is lost or repeated.
// reset (rst, synchronous) clears all valid bits and the configuration
// registers to zero.
module ray_triangle_intersect_core import rti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  rti_ray_if.sink     ray,
  rti_hit_if.source   result
);

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  logic [59:0] va, vb, vc;
  logic [47:0] nrm;
  logic [15:0] tag;

  coord_t             a [3];
  coord_t             b [3];
  coord_t             c [3];
  logic signed [15:0] nv [3];
  coord_t             in_o [3];
  coord_t             in_d [3];

  // handshake chain
  always_comb begin
    en[NSTG-1] = ~v[NSTG-1] | result.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~v[k] | en[k+1];
    end
  end

  assign ray.ready    = en[0];
  assign result.valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= ray.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= '0;
      vb  <= '0;
      vc  <= '0;
      nrm <= '0;
      tag <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VERTEX_A: va  <= cfg_data;
        REG_VERTEX_B: vb  <= cfg_data;
        REG_VERTEX_C: vc  <= cfg_data;
        REG_NORMAL:   nrm <= cfg_data[47:0];
        REG_TAG:      tag <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i]  = coord_t'(va[20*i +: 20]);
      b[i]  = coord_t'(vb[20*i +: 20]);
      c[i]  = coord_t'(vc[20*i +: 20]);
      nv[i] = $signed(nrm[16*i +: 16]);
    end
  end

  assign in_o[0] = ray.origin_x;
  assign in_o[1] = ray.origin_y;
  assign in_o[2] = ray.origin_z;
  assign in_d[0] = ray.dir_x;
  assign in_d[1] = ray.dir_y;
  assign in_d[2] = ray.dir_z;

  // stage 0: a - o
  ray_side_t s0;
  diff_t     s0_amo [3];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s0.o[i]   <= in_o[i];
        s0.d[i]   <= in_d[i];
        s0_amo[i] <= 21'(a[i]) - 21'(in_o[i]);
      end
      s0.best <= ray.best_distance;
      s0.cond <= 1'b0;
    end
  end

  // stage 1: products with the normal
  ray_side_t          s1;
  logic signed [36:0] s1_prn [3];
  logic signed [35:0] s1_prd [3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1 <= s0;
      for (int i = 0; i < 3; i++) begin
        s1_prn[i] <= 37'(s0_amo[i]) * 37'(nv[i]);
        s1_prd[i] <= 36'(coord_t'(s0.d[i])) * 36'(nv[i]);
      end
    end
  end

  // stage 2: dot products
  ray_side_t          s2;
  logic signed [38:0] s2_num, s2_den;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2     <= s1;
      s2_num <= 39'(s1_prn[0]) + 39'(s1_prn[1]) + 39'(s1_prn[2]);
      s2_den <= 39'(s1_prd[0]) + 39'(s1_prd[1]) + 39'(s1_prd[2]);
    end
  end

  // stage 3: make the denominator positive
  ray_side_t          s3;
  logic signed [39:0] s3_num;
  logic [38:0]        s3_den;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3     <= s2;
      s3_num <= s2_den[38] ? -40'(s2_num) : 40'(s2_num);
      s3_den <= s2_den[38] ? 39'(-s2_den) : 39'(s2_den);
    end
  end

  // stage 4: best * den in two partial products
  ray_side_t   s4;
  logic        s4_cond;
  logic [38:0] s4_num;
  logic [38:0] s4_den;
  logic [39:0] s4_plo;
  logic [38:0] s4_phi;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4      <= s3;
      s4_cond <= (s3_den != '0) && (s3_num > 0);
      s4_num  <= s3_num[38:0];
      s4_den  <= s3_den;
      s4_plo  <= 40'(s3.best) * 40'(s3_den[19:0]);
      s4_phi  <= 39'(s3.best) * 39'(s3_den[38:20]);
    end
  end

  // stage 5: combine partials
  ray_side_t   s5;
  logic        s5_cond;
  logic [38:0] s5_num;
  logic [38:0] s5_den;
  logic [59:0] s5_bd;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5      <= s4;
      s5_cond <= s4_cond;
      s5_num  <= s4_num;
      s5_den  <= s4_den;
      s5_bd   <= (60'(s4_phi) << 20) + 60'(s4_plo);
    end
  end

  // stage 6: range check on t, load divider
  div_word_t   s6;
  logic [59:0] n8;
  logic        t_ok;
  ray_side_t   s6_side;
  assign n8   = 60'(s5_num) << 8;
  assign t_ok = s5_cond && (n8 < s5_bd);

  always_comb begin
    s6_side      = s5;
    s6_side.cond = t_ok;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6.rem  <= t_ok ? n8 : '0;
      s6.den  <= s5_den;
      s6.q    <= '0;
      s6.side <= s6_side;
    end
  end

  div_word_t dv;
  rti_div u_div (
    .clk  (clk),
    .en   (en[DIV_FIRST +: DIV_BITS]),
    .din  (s6),
    .dout (dv)
  );

  // t * d
  ray_side_t          s27;
  logic [CW-1:0]      s27_t;
  logic signed [40:0] s27_tm [3];
  always_ff @(posedge clk) begin
    if (en[STG_TM]) begin
      s27   <= dv.side;
      s27_t <= dv.q;
      for (int i = 0; i < 3; i++) begin
        s27_tm[i] <= 41'($signed({1'b0, dv.q})) * 41'(coord_t'(dv.side.d[i]));
      end
    end
  end

  // hit point with saturation
  tail_t              s28;
  logic signed [33:0] psum [3];
  coord_t             psat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = 34'(coord_t'(s27.o[i])) + 34'(s27_tm[i] >>> 8);
      if (psum[i] > 34'sd524287) begin
        psat[i] = 20'sh7FFFF;
      end else if (psum[i] < -34'sd524288) begin
        psat[i] = 20'sh80000;
      end else begin
        psat[i] = psum[i][19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_TM+1]) begin
      s28.cond  <= s27.cond;
      s28.found <= 1'b0;
      s28.t     <= s27_t;
      s28.best  <= s27.best;
      for (int i = 0; i < 3; i++) begin
        s28.p[i] <= psat[i];
      end
    end
  end

  // edges and projection axes
  diff_t      ba [3];
  diff_t      ca [3];
  diff_t      pa [3];
  logic [2:0] ba_nz, ca_nz;
  axes_t      ax;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ba[i]    = 21'(b[i]) - 21'(a[i]);
      ca[i]    = 21'(c[i]) - 21'(a[i]);
      pa[i]    = 21'(coord_t'(s28.p[i])) - 21'(a[i]);
      ba_nz[i] = ba[i] != '0;
      ca_nz[i] = ca[i] != '0;
    end
    ax = pick_axes(ba_nz, ca_nz);
  end

  tail_t s29_in;
  always_comb begin
    s29_in       = s28;
    s29_in.found = ax.found;
  end

  tail_t s29;
  diff_t s29_pa1, s29_pa2, s29_ba1, s29_ba2, s29_ca1, s29_ca2;
  always_ff @(posedge clk) begin
    if (en[STG_TM+2]) begin
      s29     <= s29_in;
      s29_pa1 <= pa[ax.ax1];
      s29_pa2 <= pa[ax.ax2];
      s29_ba1 <= ba[ax.ax1];
      s29_ba2 <= ba[ax.ax2];
      s29_ca1 <= ca[ax.ax1];
      s29_ca2 <= ca[ax.ax2];
    end
  end

  // 2d cross products
  tail_t              s30;
  logic signed [41:0] s30_m1, s30_m2, s30_m3, s30_m4;
  diff_t              s30_pa1, s30_ba1, s30_ca1;
  always_ff @(posedge clk) begin
    if (en[STG_TM+3]) begin
      s30     <= s29;
      s30_m1  <= 42'(s29_pa2) * 42'(s29_ba1);
      s30_m2  <= 42'(s29_pa1) * 42'(s29_ba2);
      s30_m3  <= 42'(s29_ca2) * 42'(s29_ba1);
      s30_m4  <= 42'(s29_ca1) * 42'(s29_ba2);
      s30_pa1 <= s29_pa1;
      s30_ba1 <= s29_ba1;
      s30_ca1 <= s29_ca1;
    end
  end

  tail_t              s31;
  logic signed [42:0] s31_b1, s31_b2;
  diff_t              s31_pa1, s31_ba1, s31_ca1;
  always_ff @(posedge clk) begin
    if (en[STG_TM+4]) begin
      s31     <= s30;
      s31_b1  <= 43'(s30_m1) - 43'(s30_m2);
      s31_b2  <= 43'(s30_m3) - 43'(s30_m4);
      s31_pa1 <= s30_pa1;
      s31_ba1 <= s30_ba1;
      s31_ca1 <= s30_ca1;
    end
  end

  // determinant sign fix
  tail_t              s32;
  logic signed [43:0] s32_b1, s32_b2;
  diff_t              s32_pa1, s32_ba1, s32_ca1;
  always_ff @(posedge clk) begin
    if (en[STG_TM+5]) begin
      s32     <= s31;
      s32_b1  <= s31_b2[42] ? -44'(s31_b1) : 44'(s31_b1);
      s32_b2  <= s31_b2[42] ? -44'(s31_b2) : 44'(s31_b2);
      s32_pa1 <= s31_pa1;
      s32_ba1 <= s31_ba1;
      s32_ca1 <= s31_ca1;
    end
  end

  // partial products, wide operands split into 22-bit halves
  logic signed [22:0] lo1, lo2;
  logic signed [21:0] hi1, hi2;
  assign lo1 = $signed({1'b0, s32_b1[21:0]});
  assign lo2 = $signed({1'b0, s32_b2[21:0]});
  assign hi1 = s32_b1[43:22];
  assign hi2 = s32_b2[43:22];

  tail_t              s33;
  logic signed [43:0] s33_b1, s33_b2;
  logic signed [43:0] pb2l, cb1l, bb2l, bb1l;
  logic signed [42:0] pb2h, cb1h, bb2h, bb1h;
  always_ff @(posedge clk) begin
    if (en[STG_TM+6]) begin
      s33    <= s32;
      s33_b1 <= s32_b1;
      s33_b2 <= s32_b2;
      pb2l   <= 44'(s32_pa1) * 44'(lo2);
      pb2h   <= 43'(s32_pa1) * 43'(hi2);
      cb1l   <= 44'(s32_ca1) * 44'(lo1);
      cb1h   <= 43'(s32_ca1) * 43'(hi1);
      bb2l   <= 44'(s32_ba1) * 44'(lo2);
      bb2h   <= 43'(s32_ba1) * 43'(hi2);
      bb1l   <= 44'(s32_ba1) * 44'(lo1);
      bb1h   <= 43'(s32_ba1) * 43'(hi1);
    end
  end

  tail_t              s34;
  logic signed [43:0] s34_b1, s34_b2;
  logic signed [67:0] s34_an, s34_ad, s34_bn;
  always_ff @(posedge clk) begin
    if (en[STG_TM+7]) begin
      s34    <= s33;
      s34_b1 <= s33_b1;
      s34_b2 <= s33_b2;
      s34_an <= (68'(pb2h) <<< 22) + 68'(pb2l) - (68'(cb1h) <<< 22) - 68'(cb1l);
      s34_ad <= (68'(bb2h) <<< 22) + 68'(bb2l);
      s34_bn <= (68'(bb1h) <<< 22) + 68'(bb1l);
    end
  end

  tail_t              s35;
  logic signed [43:0] s35_b1, s35_b2;
  logic signed [67:0] s35_an, s35_ad, s35_bn;
  always_ff @(posedge clk) begin
    if (en[STG_TM+8]) begin
      s35    <= s34;
      s35_b1 <= s34_b1;
      s35_b2 <= s34_b2;
      s35_an <= s34_ad[67] ? -s34_an : s34_an;
      s35_ad <= s34_ad[67] ? -s34_ad : s34_ad;
      s35_bn <= s34_ad[67] ? -s34_bn : s34_bn;
    end
  end

  // final decision and output register
  logic               is_hit;
  logic signed [67:0] ab_sum;
  assign ab_sum = s35_an + s35_bn;
  assign is_hit = s35.cond && s35.found && (s35_b2 != '0) && (s35_b1 >= 0)
                  && (s35_b1 <= s35_b2) && (s35_an >= 0) && (s35_an <= s35_ad)
                  && (ab_sum <= s35_ad);

  logic          o_hit;
  logic [CW-1:0] o_dist;
  coord_t        o_p [3];
  logic [CW-1:0] o_best;
  logic [15:0]   o_tag;
  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      o_hit  <= is_hit;
      o_dist <= is_hit ? s35.t : '0;
      o_best <= is_hit ? s35.t : s35.best;
      o_tag  <= is_hit ? tag : '0;
      for (int i = 0; i < 3; i++) begin
        o_p[i] <= is_hit ? coord_t'(s35.p[i]) : '0;
      end
    end
  end

  assign result.hit          = o_hit;
  assign result.hit_distance = o_dist;
  assign result.point_x      = o_p[0];
  assign result.point_y      = o_p[1];
  assign result.point_z      = o_p[2];
  assign result.new_best     = o_best;
  assign result.hit_tag      = o_tag;

endmodule

// ===== dv/tb_ray_triangle_intersect_core.sv =====
`timescale 1ns / 1ps
module tb_ray_triangle_intersect_core;
  import rti_pkg::*;

  typedef struct {
    logic        hit;
    logic [19:0] distance;
    logic [19:0] px;
    logic [19:0] py;
    logic [19:0] pz;
    logic [19:0] nbest;
    logic [15:0] tag;
  } hit_word_t;

  class hit_scoreboard;
    logic [59:0] va, vb, vc;
    logic [47:0] nrm;
    logic [15:0] tri_tag;
    hit_word_t   pending[$];
    int          errors;

    function new();
      va = '0; vb = '0; vc = '0; nrm = '0; tri_tag = '0; errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [59:0] v);
      case (idx)
        REG_VERTEX_A: va = v;
        REG_VERTEX_B: vb = v;
        REG_VERTEX_C: vc = v;
        REG_NORMAL:   nrm = v[47:0];
        REG_TAG:      tri_tag = v[15:0];
        default: ;
      endcase
    endfunction

    static function longint fdiv256(longint v);
      if (v >= 0) return v / 256;
      return -((-v + 255) / 256);
    endfunction

    function void note_ray(logic [19:0] o[3], logic [19:0] d[3], logic [19:0] best);
      longint a[3], b[3], c[3], n[3], oo[3], dd[3], p[3], ba[3], ca[3], pa[3];
      longint num, den, bst, t, v, b1, b2, an, ad, bn;
      int ax1, ax2;
      bit hit;
      hit_word_t w;
      num = 0; den = 0; t = 0; hit = 0; ax1 = -1; ax2 = -1;
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'($signed(va[20*i +: 20]));
        b[i] = longint'($signed(vb[20*i +: 20]));
        c[i] = longint'($signed(vc[20*i +: 20]));
        n[i] = longint'($signed(nrm[16*i +: 16]));
        oo[i] = longint'($signed(o[i]));
        dd[i] = longint'($signed(d[i]));
        p[i] = 0;
      end
      bst = longint'(best);
      for (int i = 0; i < 3; i++) begin
        num += (a[i] - oo[i]) * n[i];
        den += dd[i] * n[i];
      end
      if (den < 0) begin
        num = -num; den = -den;
      end
      if (den != 0 && num > 0 && num * 256 < bst * den) begin
        t = (num * 256) / den;
        for (int i = 0; i < 3; i++) begin
          v = oo[i] + fdiv256(t * dd[i]);
          if (v > 524287) v = 524287;
          if (v < -524288) v = -524288;
          p[i] = v;
          ba[i] = b[i] - a[i];
          ca[i] = c[i] - a[i];
          pa[i] = p[i] - a[i];
        end
        for (int i = 0; i < 3; i++) begin
          if (ax2 < 0 && ba[i] != 0) begin
            for (int j = 0; j < 3; j++) begin
              if (ax2 < 0 && j != i && ca[j] != 0) begin
                ax1 = i; ax2 = j;
              end
            end
          end
        end
        if (ax2 >= 0) begin
          b1 = pa[ax2] * ba[ax1] - pa[ax1] * ba[ax2];
          b2 = ca[ax2] * ba[ax1] - ca[ax1] * ba[ax2];
          if (b2 != 0) begin
            if (b2 < 0) begin
              b1 = -b1; b2 = -b2;
            end
            an = pa[ax1] * b2 - b1 * ca[ax1];
            ad = b2 * ba[ax1];
            bn = b1 * ba[ax1];
            if (ad < 0) begin
              an = -an; ad = -ad; bn = -bn;
            end
            if (b1 >= 0 && b1 <= b2 && an >= 0 && an <= ad && an + bn <= ad) hit = 1;
          end
        end
      end
      if (hit) begin
        w.hit = 1; w.distance = t[19:0]; w.px = p[0][19:0]; w.py = p[1][19:0];
        w.pz = p[2][19:0]; w.nbest = t[19:0]; w.tag = tri_tag;
      end else begin
        w.hit = 0; w.distance = 0; w.px = 0; w.py = 0; w.pz = 0; w.nbest = best; w.tag = 0;
      end
      pending.push_back(w);
    endfunction

    function void check_word(hit_word_t got);
      hit_word_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word hit=%0b", $realtime, got.hit);
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        errors++; $display("%0t: hit exp %0b got %0b", $realtime, e.hit, got.hit);
      end
      if (got.distance !== e.distance) begin
        errors++;
        $display("%0t: hit_distance exp %h got %h", $realtime, e.distance, got.distance);
      end
      if (got.px !== e.px) begin
        errors++; $display("%0t: point_x exp %h got %h", $realtime, e.px, got.px);
      end
      if (got.py !== e.py) begin
        errors++; $display("%0t: point_y exp %h got %h", $realtime, e.py, got.py);
      end
      if (got.pz !== e.pz) begin
        errors++; $display("%0t: point_z exp %h got %h", $realtime, e.pz, got.pz);
      end
      if (got.nbest !== e.nbest) begin
        errors++; $display("%0t: new_best exp %h got %h", $realtime, e.nbest, got.nbest);
      end
      if (got.tag !== e.tag) begin
        errors++; $display("%0t: hit_tag exp %h got %h", $realtime, e.tag, got.tag);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [59:0] cfg_data = '0;
  rti_ray_if ray ();
  rti_hit_if result ();
  hit_scoreboard sb = new();
  int unsigned cycles = 0;
  bit stim_done = 0;

  ray_triangle_intersect_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray(ray.sink), .result(result.source)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    ray.valid = 0; ray.origin_x = 0; ray.origin_y = 0; ray.origin_z = 0;
    ray.dir_x = 0; ray.dir_y = 0; ray.dir_z = 0; ray.best_distance = 0;
    result.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // scoreboard sampling at the rising edge
  always @(posedge clk) begin
    hit_word_t g;
    logic [19:0] o[3], d[3];
    if (!rst && ray.valid && ray.ready) begin
      o[0] = ray.origin_x; o[1] = ray.origin_y; o[2] = ray.origin_z;
      d[0] = ray.dir_x; d[1] = ray.dir_y; d[2] = ray.dir_z;
      sb.note_ray(o, d, ray.best_distance);
    end
    if (!rst && result.valid && result.ready) begin
      g.hit = result.hit; g.distance = result.hit_distance; g.px = result.point_x;
      g.py = result.point_y; g.pz = result.point_z; g.nbest = result.new_best;
      g.tag = result.hit_tag;
      sb.check_word(g);
    end
  end

  // receiver stalls
  initial begin
    int w;
    @(negedge clk);
    while (1) begin
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (stim_done && $urandom_range(0, 1)) w = 0;
      if (w > 0) begin
        result.ready <= 0;
        repeat (w) @(negedge clk);
      end
      result.ready <= 1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [59:0] v);
    cfg_we = 1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_ray(logic [19:0] ox, oy, oz, dx, dy, dz, bd, bit burst);
    int w;
    w = burst ? 0 : $urandom_range(0, 19);
    if (w > 0) begin
      ray.valid <= 0;
      repeat (w) @(negedge clk);
    end
    ray.valid <= 1;
    ray.origin_x <= ox; ray.origin_y <= oy; ray.origin_z <= oz;
    ray.dir_x <= dx; ray.dir_y <= dy; ray.dir_z <= dz; ray.best_distance <= bd;
    @(posedge clk);
    while (!ray.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    ray.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [19:0] rnd20();
    case ($urandom_range(0, 5))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'(int'($urandom_range(0, 2048)) - 1024);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [59:0] pack3(int x, int y, int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  // small triangle in plane z = zc, normal +z, rays mostly toward it; full_rand: random registers and rays
  task automatic random_phase(int count, bit full_rand);
    int ax, ay, zc, ox, oy, oz, tx, ty, s;
    logic [19:0] dx, dy, dz, bd;
    bit burst;
    if (full_rand) begin
      write_reg(REG_VERTEX_A, 60'({$urandom, $urandom}));
      write_reg(REG_VERTEX_B, 60'({$urandom, $urandom}));
      write_reg(REG_VERTEX_C, 60'({$urandom, $urandom}));
      write_reg(REG_NORMAL, 60'({$urandom, $urandom}));
    end else begin
      ax = $urandom_range(0, 4000) - 2000; ay = $urandom_range(0, 4000) - 2000;
      zc = $urandom_range(0, 4000) - 2000; s = $urandom_range(64, 2048);
      write_reg(REG_VERTEX_A, pack3(ax, ay, zc));
      write_reg(REG_VERTEX_B, pack3(ax + s, ay, zc));
      write_reg(REG_VERTEX_C, pack3(ax, ay + s, zc));
      write_reg(REG_NORMAL, 60'({16'h4000, 16'h0, 16'h0}));
    end
    write_reg(REG_TAG, 60'(16'($urandom)));
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if (full_rand || $urandom_range(0, 4) == 0) begin
        send_ray(rnd20(), rnd20(), rnd20(), rnd20(), rnd20(), rnd20(), rnd20(), burst);
      end else begin
        ox = ax + $urandom_range(0, 2 * s) - s / 2;
        oy = ay + $urandom_range(0, 2 * s) - s / 2;
        oz = zc + $urandom_range(0, 4000) - 2000;
        tx = ax + $urandom_range(0, s); ty = ay + $urandom_range(0, s);
        dx = 20'((tx - ox) / 2); dy = 20'((ty - oy) / 2); dz = 20'((zc - oz) / 2);
        bd = $urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom_range(0, 1200));
        send_ray(20'(ox), 20'(oy), 20'(oz), dx, dy, dz, bd, burst);
      end
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // reset registers: degenerate triangle, zero normal
    send_ray(20'h7FFFF, 20'h80000, 0, 20'h00100, 0, 0, 20'hFFFFF, 0);
    drain();
    write_reg(REG_VERTEX_A, pack3(0, 0, 2560));
    write_reg(REG_VERTEX_B, pack3(2560, 0, 2560));
    write_reg(REG_VERTEX_C, pack3(0, 2560, 2560));
    write_reg(REG_NORMAL, 60'({16'h4000, 16'h0, 16'h0}));
    write_reg(REG_TAG, 60'(16'hFFFF));
    send_ray(20'd256, 20'd256, 0, 0, 0, 20'd256, 20'hFFFFF, 0);
    send_ray(20'd256, 20'd256, 0, 0, 0, 20'd256, 20'd2560, 0);
    send_ray(20'd256, 20'd256, 0, 0, 0, 20'd256, 20'd2561, 0);
    send_ray(20'd0, 20'd0, 0, 0, 0, 20'd256, 20'hFFFFF, 0);
    send_ray(20'd1280, 20'd1280, 0, 0, 0, 20'd256, 20'hFFFFF, 0);
    send_ray(20'd1281, 20'd1280, 0, 0, 0, 20'd256, 20'hFFFFF, 0);
    send_ray(20'd256, 20'd256, 0, 20'd256, 0, 0, 20'hFFFFF, 0);
    send_ray(20'd256, 20'd256, 20'd2559, 0, 0, 20'h7FFFF, 20'hFFFFF, 0);
    send_ray(20'd256, 20'd256, 20'd5000, 0, 0, 20'h80000, 20'hFFFFF, 0);
    send_ray(20'd256, 20'd256, 20'd5000, 0, 0, 20'd256, 20'hFFFFF, 0);
    send_ray(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'hFFFFF, 0);
    send_ray(20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 0, 0);
    drain();
    // collinear edges: no axis pair
    write_reg(REG_VERTEX_C, pack3(5120, 0, 2560));
    send_ray(20'd256, 0, 0, 0, 0, 20'd256, 20'hFFFFF, 0);
    drain();
    // extreme register values
    write_reg(REG_VERTEX_A, 60'hFFFFFFFFFFFFFFF);
    write_reg(REG_VERTEX_B, 60'h800008000080000);
    write_reg(REG_VERTEX_C, 60'h7FFFF7FFFF7FFFF);
    write_reg(REG_NORMAL, 60'h80007FFFFFFF);
    write_reg(REG_TAG, 60'h0);
    send_ray(0, 0, 0, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'hFFFFF, 0);
    send_ray(20'h80000, 20'h7FFFF, 0, 20'h80000, 20'h7FFFF, 20'h1, 20'hFFFFF, 0);
    drain();
    for (int ph = 0; ph < 16; ph++) random_phase(100, ph % 4 == 3);
    stim_done = 1;
    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== ray_triangle_intersect_core.f =====
design/rti_pkg.sv
design/rti_ray_if.sv
design/rti_hit_if.sv
design/rti_div.sv
design/ray_triangle_intersect_core.sv
dv/tb_ray_triangle_intersect_core.sv
